FILE: rtl/core/pdws_pkg.sv
// ----------------------------------------------------------------------------
// PLL divider word search package
// Shared widths, constants, register indexes, sequencer states and the
// request/response structs of the shared divider.
// ----------------------------------------------------------------------------
package pdws_pkg;

  localparam int unsigned FREQ_W    = 22;
  localparam int unsigned REF_W     = 25;
  localparam int unsigned PORT_W    = 2;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 25;
  localparam int unsigned HZ_W      = 32;
  localparam int unsigned DVD_W     = HZ_W + 1;
  localparam int unsigned DSR_W     = REF_W + 1;
  localparam int unsigned CNT_W     = $clog2(DVD_W);
  localparam int unsigned NDIV_W    = 17;
  localparam int unsigned RIDX_W    = 4;

  localparam logic [REF_W-1:0]  REF_CLOCK_RESET = REF_W'(4000000);
  localparam logic [PORT_W-1:0] PORT_BITS_RESET = '0;

  localparam logic [FREQ_W-1:0] CP_BAND0_KHZ  = FREQ_W'(1100000);
  localparam logic [FREQ_W-1:0] CP_BAND1_KHZ  = FREQ_W'(1200000);
  localparam logic [FREQ_W-1:0] CP_BAND2_KHZ  = FREQ_W'(1600000);
  localparam logic [FREQ_W-1:0] CP_BAND3_KHZ  = FREQ_W'(1800000);
  localparam logic [FREQ_W-1:0] CP_BAND4_KHZ  = FREQ_W'(2000000);
  localparam logic [FREQ_W-1:0] PRESCALE_KHZ  = FREQ_W'(2300000);
  localparam logic [FREQ_W-1:0] FREQ_MAX_KHZ  = FREQ_W'(2700000);
  localparam logic [9:0]        KHZ_TO_HZ     = 10'd1000;

  localparam logic [RIDX_W-1:0] LAST_RATIO = RIDX_W'(9);
  localparam logic [RIDX_W-1:0] CODE_SKIP  = RIDX_W'(3);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REF_CLOCK = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_BITS = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP_START,
    ST_STEP_WAIT,
    ST_FREQ_START,
    ST_FREQ_WAIT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
    logic [DSR_W-1:0] remainder;
  } div_rsp_t;

  // Reference ratios in search order.
  function automatic logic [5:0] ratio_of(input logic [RIDX_W-1:0] idx);
    logic [5:0] r;
    unique case (idx)
      4'd0:    r = 6'd2;
      4'd1:    r = 6'd4;
      4'd2:    r = 6'd8;
      4'd3:    r = 6'd16;
      4'd4:    r = 6'd32;
      4'd5:    r = 6'd24;
      4'd6:    r = 6'd5;
      4'd7:    r = 6'd10;
      4'd8:    r = 6'd20;
      4'd9:    r = 6'd40;
      default: r = 6'd2;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/pdws_intf.sv
// ----------------------------------------------------------------------------
// PLL divider word search channels
// Valid/ready channels for the frequency request, the programming word
// response and the configuration writes.
// ----------------------------------------------------------------------------
interface pdws_req_if;
  logic                        valid;
  logic                        ready;
  logic [pdws_pkg::FREQ_W-1:0] freq_khz;

  modport source (output valid, output freq_khz, input ready);
  modport sink   (input valid, input freq_khz, output ready);
endinterface

interface pdws_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;
  logic [7:0] byte3;
  logic       invalid;

  modport source (output valid, output byte0, output byte1, output byte2,
                  output byte3, output invalid, input ready);
  modport sink   (input valid, input byte0, input byte1, input byte2,
                  input byte3, input invalid, output ready);
endinterface

interface pdws_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pdws_pkg::CFG_IDX_W-1:0] index;
  logic [pdws_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/pdws_divider.sv
// ----------------------------------------------------------------------------
// PLL divider word search shared divider
// Restoring divider producing one quotient bit per cycle, with remainder.
// ----------------------------------------------------------------------------
module pdws_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pdws_pkg::div_req_t req_i,
  output pdws_pkg::div_rsp_t rsp_o
);
  import pdws_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] dq_q, dq_d;
  logic [DSR_W-1:0] dsr_q, dsr_d;
  logic [DSR_W-1:0] rem_q, rem_d;
  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;
  logic             ge;

  assign trial = {rem_q, dq_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dq_d   = req_i.dividend;
      dsr_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      // The partial remainder always stays below the divisor, so it fits.
      rem_d = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      dq_d  = {dq_q[DVD_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = dq_q;
  assign rsp_o.remainder = rem_q;

endmodule

FILE: rtl/core/pll_divider_word_search.sv
// ----------------------------------------------------------------------------
// PLL divider word search
// Searches ten reference ratios for the divider closest to the requested
// frequency and returns the four-byte synthesizer programming word.
// ----------------------------------------------------------------------------
// Search: each ratio costs two divisions through the one shared 33-step divider;
// a skipped ratio costs one division, an exact hit ends the search early and an
// out-of-range request goes straight to the finish state with no division.
// Throughput: one request at a time.
// Reset: asynchronous, active low; config registers return to defaults, sequencer idles.
module pll_divider_word_search (
  input logic       clk_i,
  input logic       rst_ni,
  pdws_req_if.sink  req_i,
  pdws_rsp_if.source rsp_o,
  pdws_cfg_if.sink  cfg_i
);
  import pdws_pkg::*;

  state_e state_q, state_d;

  logic [REF_W-1:0]  ref_clock_q;
  logic [PORT_W-1:0] port_bits_q;

  logic [HZ_W-1:0]   hz_q;
  logic              pe_q;
  logic [1:0]        cp_q, cp_d;
  logic [RIDX_W-1:0] idx_q;
  logic [DSR_W-1:0]  step_q;
  logic [DSR_W-1:0]  best_q;
  logic [NDIV_W-1:0] ndiv_q;
  logic [RIDX_W-1:0] code_q;
  logic              inval_q;

  logic              out_valid_q;
  logic [7:0]        byte0_q, byte1_q, byte2_q, byte3_q;
  logic              out_inval_q;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              accept;
  logic              too_high;
  logic              load_out;
  logic [DSR_W-1:0]  step_new;
  logic              step_zero;
  logic [DSR_W-2:0]  half;
  logic [DSR_W-1:0]  mag;
  logic              take;
  logic              last;

  pdws_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign accept   = req_i.valid && req_i.ready;
  assign too_high = req_i.freq_khz > FREQ_MAX_KHZ;
  assign load_out = (state_q == ST_FINISH) && (!out_valid_q || rsp_o.ready);

  assign step_new  = pe_q ? {div_rsp.quotient[DSR_W-2:0], 1'b0}
                          : {1'b0, div_rsp.quotient[DSR_W-2:0]};
  assign step_zero = (div_rsp.quotient[DSR_W-2:0] == '0);
  assign half      = step_q[DSR_W-1:1];
  // The rounding bias is folded into the dividend, so the signed error is
  // the remainder less half a step.
  assign mag  = (div_rsp.remainder >= {1'b0, half}) ? div_rsp.remainder - {1'b0, half}
                                                   : {1'b0, half} - div_rsp.remainder;
  assign take = (mag <= best_q);
  assign last = (idx_q == LAST_RATIO);

  always_comb begin
    priority if (req_i.freq_khz < CP_BAND0_KHZ) cp_d = 2'd2;
    else if (req_i.freq_khz < CP_BAND1_KHZ)     cp_d = 2'd1;
    else if (req_i.freq_khz < CP_BAND2_KHZ)     cp_d = 2'd0;
    else if (req_i.freq_khz < CP_BAND3_KHZ)     cp_d = 2'd1;
    else if (req_i.freq_khz < CP_BAND4_KHZ)     cp_d = 2'd2;
    else                                        cp_d = 2'd3;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = too_high ? ST_FINISH : ST_STEP_START;
      end
      ST_STEP_START: state_d = ST_STEP_WAIT;
      ST_STEP_WAIT: begin
        if (div_rsp.done) begin
          if (!step_zero)  state_d = ST_FREQ_START;
          else if (last)   state_d = ST_FINISH;
          else             state_d = ST_STEP_START;
        end
      end
      ST_FREQ_START: state_d = ST_FREQ_WAIT;
      ST_FREQ_WAIT: begin
        if (div_rsp.done) begin
          if ((take && mag == '0) || last) state_d = ST_FINISH;
          else                              state_d = ST_STEP_START;
        end
      end
      ST_FINISH: begin
        if (load_out) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    req_i.ready      = (state_q == ST_IDLE);
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    unique case (state_q)
      ST_STEP_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = DVD_W'(ref_clock_q) + DVD_W'(ratio_of(idx_q) >> 1);
        div_req.divisor  = DSR_W'(ratio_of(idx_q));
      end
      ST_FREQ_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = DVD_W'(hz_q) + DVD_W'(half);
        div_req.divisor  = step_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ref_clock_q <= REF_CLOCK_RESET;
      port_bits_q <= PORT_BITS_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == CFG_REF_CLOCK) ref_clock_q <= cfg_i.data[REF_W-1:0];
        if (cfg_i.index == CFG_PORT_BITS) port_bits_q <= cfg_i.data[PORT_W-1:0];
      end
      if (load_out)              out_valid_q <= 1'b1;
      else if (rsp_o.ready)      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hz_q    <= HZ_W'(req_i.freq_khz) * HZ_W'(KHZ_TO_HZ);
      pe_q    <= (req_i.freq_khz > PRESCALE_KHZ);
      cp_q    <= cp_d;
      inval_q <= too_high;
      idx_q   <= '0;
      best_q  <= '1;
      ndiv_q  <= '0;
      code_q  <= '0;
    end
    if (state_q == ST_STEP_WAIT && div_rsp.done) begin
      step_q <= step_new;
      if (step_zero && !last) idx_q <= idx_q + 1'b1;
    end
    if (state_q == ST_FREQ_WAIT && div_rsp.done) begin
      if (take) begin
        best_q <= mag;
        ndiv_q <= div_rsp.quotient[NDIV_W-1:0];
        code_q <= (idx_q > RIDX_W'(4)) ? idx_q + CODE_SKIP : idx_q;
      end
      if (!last) idx_q <= idx_q + 1'b1;
    end
    if (load_out) begin
      out_inval_q <= inval_q;
      if (inval_q) begin
        byte0_q <= '0;
        byte1_q <= '0;
        byte2_q <= '0;
        byte3_q <= '0;
      end else begin
        byte0_q <= {1'b0, ndiv_q[14:8]};
        byte1_q <= ndiv_q[7:0];
        byte2_q <= {1'b1, ndiv_q[16:15], pe_q, code_q};
        byte3_q <= {cp_q, port_bits_q, 4'b0000};
      end
    end
  end

  assign cfg_i.ready   = 1'b1;
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.byte0   = byte0_q;
  assign rsp_o.byte1   = byte1_q;
  assign rsp_o.byte2   = byte2_q;
  assign rsp_o.byte3   = byte3_q;
  assign rsp_o.invalid = out_inval_q;

endmodule
